### rtl/core/gpl_pkg.sv
// Shared types and constants for the georeferenced pixel lookup.
`default_nettype none
package gpl_pkg;

  localparam int DIV_STEPS = 33;             // quotient bits below the overflow limit
  localparam int ST_DIV0   = 3;              // stage holding the divider start state
  localparam int ST_XCHK   = ST_DIV0 + DIV_STEPS + 1;
  localparam int ST_ADDR   = ST_XCHK;        // stage holding the checked store address
  localparam int NUM_ST    = ST_ADDR + 1;
  localparam int CELL_W    = 12;

  typedef enum logic [2:0] {
    REG_PIX_X_A   = 3'd0,
    REG_PIX_Y_A   = 3'd1,
    REG_WORLD_E_A = 3'd2,
    REG_WORLD_N_A = 3'd3,
    REG_PIX_X_B   = 3'd4,
    REG_PIX_Y_B   = 3'd5,
    REG_WORLD_E_B = 3'd6,
    REG_WORLD_N_B = 3'd7
  } reg_idx_t;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [31:0] RST_ANCHOR_A = 32'd0;
  localparam logic [31:0] RST_ANCHOR_B = 32'd256;

  // per-item data that travels with every stage
  typedef struct packed {
    logic        valid;
    logic        func;
    logic [15:0] idx;
    logic [23:0] rgb;
  } meta_t;

  // per-axis mapping data carried down to the divider's end
  typedef struct packed {
    logic [32:0]        mdw;
    logic               neg;
    logic               bad;
    logic signed [31:0] pa;
  } axis_t;

endpackage
`default_nettype wire

### rtl/core/georef_pixel_lookup.sv
// Top level: pipelined world-to-pixel mapping and RGB image store.
//
//  channel  | signals                                         | transfer when
//  ---------+-------------------------------------------------+------------------------
//  input    | func pixel_index red_in green_in blue_in east   | in_valid && in_ready
//           | north                                           |
//  output   | red_out green_out blue_out outside              | out_valid && out_ready
//  config   | cfg_we cfg_index cfg_data                       | cfg_we
//
// One item per cycle while the output is not stalled.
// The pipe length is set by the restoring divider, one quotient bit per stage over
// 33 stages, plus product, mapping and store read stages. Loads travel the same
// pipe and write the store at the stage where lookups read it, so order holds.
// Reset clears stage valid bits and sets the anchors to their reset values; the store is not cleared.
// A stalled output freezes the whole pipe; in_ready follows the output side.
`default_nettype none
module georef_pixel_lookup import gpl_pkg::*; #(
  parameter int IMG_WIDTH  = 256,
  parameter int IMG_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               func,
  input  wire logic [15:0]        pixel_index,
  input  wire logic [7:0]         red_in,
  input  wire logic [7:0]         green_in,
  input  wire logic [7:0]         blue_in,
  input  wire logic signed [31:0] east,
  input  wire logic signed [31:0] north,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [7:0]         red_out,
  output      logic [7:0]         green_out,
  output      logic [7:0]         blue_out,
  output      logic               outside,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam logic [34:0] LIM_X = 35'((IMG_WIDTH - 1) << FRAC_BITS);
  localparam logic [34:0] LIM_Y = 35'((IMG_HEIGHT - 1) << FRAC_BITS);

  logic [31:0] cfg [8];
  logic        adv;
  meta_t       meta [NUM_ST];

  // axis 0 is east -> x, axis 1 is north -> y
  logic [32:0] c_mdp [2], c_mdv [2], c_mdw [2];
  logic        c_neg [2];
  logic        c_zero [2];

  logic [32:0] s0_mdp [2], s0_mdv [2];
  logic [33:0] s1_ll [2];
  logic [32:0] s1_lh [2], s1_hl [2];
  logic [31:0] s1_hh [2];
  logic [63:0] s2_prod [2];
  axis_t       car [2][ST_XCHK];
  logic [32:0] rem [2][ST_DIV0:ST_XCHK-1];
  logic [32:0] lo  [2][ST_DIV0:ST_XCHK-1];
  logic        x_ok [2];
  logic [CELL_W-1:0] pix_pos [2];
  logic        a_ok;
  logic [15:0] a_addr;

  logic [23:0] store [65536];
  logic [23:0] rd_q;
  logic        bad_q;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[REG_PIX_X_A]   <= RST_ANCHOR_A;
      cfg[REG_PIX_Y_A]   <= RST_ANCHOR_A;
      cfg[REG_WORLD_E_A] <= RST_ANCHOR_A;
      cfg[REG_WORLD_N_A] <= RST_ANCHOR_A;
      cfg[REG_PIX_X_B]   <= RST_ANCHOR_B;
      cfg[REG_PIX_Y_B]   <= RST_ANCHOR_B;
      cfg[REG_WORLD_E_B] <= RST_ANCHOR_B;
      cfg[REG_WORLD_N_B] <= RST_ANCHOR_B;
    end else if (cfg_we) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  // spans and offsets at the input
  always_comb begin
    logic [31:0] pa, pb, wa, wb, pt;
    logic [32:0] dp, dw, dv;
    for (int a = 0; a < 2; a++) begin
      pa = (a == 0) ? cfg[REG_PIX_X_A]   : cfg[REG_PIX_Y_A];
      pb = (a == 0) ? cfg[REG_PIX_X_B]   : cfg[REG_PIX_Y_B];
      wa = (a == 0) ? cfg[REG_WORLD_E_A] : cfg[REG_WORLD_N_A];
      wb = (a == 0) ? cfg[REG_WORLD_E_B] : cfg[REG_WORLD_N_B];
      pt = (a == 0) ? east : north;
      dp = {pb[31], pb} - {pa[31], pa};
      dw = {wb[31], wb} - {wa[31], wa};
      dv = {pt[31], pt} - {wa[31], wa};
      c_mdp[a]  = dp[32] ? -dp : dp;
      c_mdw[a]  = dw[32] ? -dw : dw;
      c_mdv[a]  = dv[32] ? -dv : dv;
      c_neg[a]  = dp[32] ^ dv[32] ^ dw[32];
      c_zero[a] = (dw == 33'd0);
    end
  end

  // final mapping check and address, combinational from their stages
  always_comb begin
    logic [34:0] q, x;
    for (int a = 0; a < 2; a++) begin
      q = {2'b00, lo[a][ST_XCHK-1]};
      if (car[a][ST_XCHK-1].neg) q = -q;
      x = {{3{car[a][ST_XCHK-1].pa[31]}}, car[a][ST_XCHK-1].pa} + q;
      x_ok[a] = !car[a][ST_XCHK-1].bad && !x[34] && (x <= ((a == 0) ? LIM_X : LIM_Y));
      pix_pos[a] = CELL_W'(x >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    logic [33:0] t;
    axis_t       div_in;
    if (rst) begin
      for (int i = 0; i < NUM_ST; i++) meta[i].valid <= 1'b0;
    end else if (adv) begin
      meta[0].valid <= in_valid;
      for (int i = 1; i < NUM_ST; i++) meta[i].valid <= meta[i-1].valid;
    end
    if (adv) begin
      meta[0].func <= func;
      meta[0].idx  <= pixel_index;
      meta[0].rgb  <= {red_in, green_in, blue_in};
      for (int i = 1; i < NUM_ST; i++) begin
        meta[i].func <= meta[i-1].func;
        meta[i].idx  <= meta[i-1].idx;
        meta[i].rgb  <= meta[i-1].rgb;
      end
      for (int a = 0; a < 2; a++) begin
        // stage 0: magnitudes
        s0_mdp[a]        <= c_mdp[a];
        s0_mdv[a]        <= c_mdv[a];
        car[a][0].mdw    <= c_mdw[a];
        car[a][0].neg    <= c_neg[a];
        car[a][0].bad    <= c_zero[a];
        car[a][0].pa     <= (a == 0) ? cfg[REG_PIX_X_A] : cfg[REG_PIX_Y_A];
        for (int i = 1; i < ST_XCHK; i++) begin
          if (i != ST_DIV0) car[a][i] <= car[a][i-1];
        end
        // stage 1: partial products
        s1_ll[a] <= 34'(s0_mdp[a][16:0]) * 34'(s0_mdv[a][16:0]);
        s1_lh[a] <= 33'(s0_mdp[a][16:0]) * 33'(s0_mdv[a][32:17]);
        s1_hl[a] <= 33'(s0_mdp[a][32:17]) * 33'(s0_mdv[a][16:0]);
        s1_hh[a] <= 32'(s0_mdp[a][32:17]) * 32'(s0_mdv[a][32:17]);
        // stage 2: full product
        s2_prod[a] <= 64'(s1_ll[a]) + (64'(s1_lh[a]) << 17) + (64'(s1_hl[a]) << 17)
                    + (64'(s1_hh[a]) << 34);
        // stage 3: overflow when the quotient would reach 2^33
        rem[a][ST_DIV0] <= {2'b00, s2_prod[a][63:33]};
        lo[a][ST_DIV0]  <= s2_prod[a][32:0];
        div_in = car[a][ST_DIV0-1];
        if ({2'b00, s2_prod[a][63:33]} >= car[a][ST_DIV0-1].mdw)
          div_in.bad = 1'b1;
        car[a][ST_DIV0] <= div_in;
        // restoring divider, one quotient bit per stage
        for (int i = ST_DIV0 + 1; i < ST_XCHK; i++) begin
          t = {rem[a][i-1], lo[a][i-1][32]};
          if (t >= {1'b0, car[a][i-1].mdw}) begin
            rem[a][i] <= 33'(t - {1'b0, car[a][i-1].mdw});
            lo[a][i]  <= {lo[a][i-1][31:0], 1'b1};
          end else begin
            rem[a][i] <= t[32:0];
            lo[a][i]  <= {lo[a][i-1][31:0], 1'b0};
          end
        end
      end
      a_ok   <= x_ok[0] && x_ok[1];
      a_addr <= 16'(25'(pix_pos[1]) * 25'(IMG_WIDTH) + 25'(pix_pos[0]));
    end
  end

  // store access and result register
  always_ff @(posedge clk) begin
    if (adv && meta[ST_ADDR].valid) begin
      if (meta[ST_ADDR].func == FUNC_LOAD) begin
        store[meta[ST_ADDR].idx] <= meta[ST_ADDR].rgb;
      end else if (a_ok) begin
        rd_q <= store[a_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= meta[ST_ADDR].valid && (meta[ST_ADDR].func == FUNC_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) bad_q <= !a_ok;
  end

  assign outside   = bad_q;
  assign red_out   = bad_q ? 8'hFF : rd_q[23:16];
  assign green_out = bad_q ? 8'hFF : rd_q[15:8];
  assign blue_out  = bad_q ? 8'hFF : rd_q[7:0];

endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the georeferenced pixel lookup.
`timescale 1ns / 1ps
module testbench;
  import gpl_pkg::*;

  localparam int W = 256;
  localparam int H = 256;
  localparam int FB = 8;
  localparam int LATENCY = 38;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       off;
  } pix_res_t;

  typedef struct {
    logic        fn;
    logic [15:0] idx;
    logic [23:0] rgb;
    logic [31:0] e;
    logic [31:0] n;
    logic        known;
    pix_res_t    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_LOAD;
  logic [15:0] pixel_index = '0;
  logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
  logic signed [31:0] east = '0, north = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red_out, green_out, blue_out;
  logic outside;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #6 clk = ~clk;

  georef_pixel_lookup uut (.*);

  // predictor state
  logic [23:0] img_mirror [0:65535];
  bit          img_written [0:65535];
  logic signed [31:0] anchor [0:7];
  pix_res_t pending_pix[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;

  function automatic bit map_axis(input logic signed [31:0] p, pa, pb, wa, wb,
                                  input longint lim, output longint pos);
    longint dp, dw, dv, x;
    logic [63:0] q;
    logic [63:0] mdp, mdv, mdw;
    bit neg;
    dp = longint'(pb) - longint'(pa);
    dw = longint'(wb) - longint'(wa);
    dv = longint'(p) - longint'(wa);
    pos = 0;
    if (dw == 0) return 1'b0;
    neg = ((dp < 0) != (dv < 0)) != (dw < 0);
    mdp = dp < 0 ? -dp : dp;
    mdv = dv < 0 ? -dv : dv;
    mdw = dw < 0 ? -dw : dw;
    q = (mdp * mdv) / mdw;
    if (q >= (64'd1 << 33)) return 1'b0;
    x = longint'(pa) + (neg ? -longint'(q) : longint'(q));
    if (x < 0 || x > lim) return 1'b0;
    pos = x >>> FB;
    return 1'b1;
  endfunction

  function automatic bit lookup_pix(input logic [31:0] e, n, output pix_res_t res,
                                    output logic [15:0] addr);
    longint cx, cy;
    bit ok;
    ok = map_axis(e, anchor[REG_PIX_X_A], anchor[REG_PIX_X_B], anchor[REG_WORLD_E_A],
                  anchor[REG_WORLD_E_B], longint'(W - 1) << FB, cx);
    if (ok)
      ok = map_axis(n, anchor[REG_PIX_Y_A], anchor[REG_PIX_Y_B], anchor[REG_WORLD_N_A],
                    anchor[REG_WORLD_N_B], longint'(H - 1) << FB, cy);
    addr = 16'(cy * W + cx);
    if (!ok) res = '{8'hFF, 8'hFF, 8'hFF, 1'b1};
    else res = {img_mirror[addr], 1'b0};
    return ok;
  endfunction

  task automatic send_item(input stim_row_t row);
    pix_res_t res;
    logic [15:0] addr;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    func <= row.fn;
    pixel_index <= row.idx;
    {red_in, green_in, blue_in} <= row.rgb;
    east <= row.e;
    north <= row.n;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (row.fn == FUNC_LOAD) begin
      img_mirror[row.idx] = row.rgb;
      img_written[row.idx] = 1'b1;
    end else begin
      void'(lookup_pix(row.e, row.n, res, addr));
      if (row.known && res != row.res) begin
        $display("%0t: table mismatch expected %h actual %h", $time, row.res, res);
        errors++;
      end
      pending_pix.push_back(res);
    end
  endtask

  // receiver
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_pix.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h %h %h %b", $time,
                   red_out, green_out, blue_out, outside);
          errors++;
        end else begin
          pix_res_t exp_r;
          exp_r = pending_pix.pop_front();
          if (exp_r != {red_out, green_out, blue_out, outside}) begin
            $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                     exp_r.r, exp_r.g, exp_r.b, exp_r.off,
                     red_out, green_out, blue_out, outside);
            errors++;
          end
        end
      end
      out_ready <= !recv_hold && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_anchor(input reg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    anchor[idx] = val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // random lookup that lands on a written pixel or outside, else a load of that pixel
  task automatic rand_lookup(output stim_row_t row);
    pix_res_t res;
    logic [15:0] addr;
    int tries;
    row.fn = FUNC_LOOKUP;
    row.idx = 16'($urandom);
    row.rgb = 24'($urandom);
    row.known = 1'b0;
    tries = 0;
    do begin
      case ($urandom_range(3))
        0: begin row.e = $urandom; row.n = $urandom; end
        1: begin
          row.e = anchor[REG_WORLD_E_A] + $signed($urandom_range(2000)) - 500;
          row.n = anchor[REG_WORLD_N_A] + $signed($urandom_range(2000)) - 500;
        end
        default: begin
          row.e = anchor[REG_WORLD_E_A] +
                  ((anchor[REG_WORLD_E_B] - anchor[REG_WORLD_E_A]) >>> 8) * $urandom_range(300);
          row.n = anchor[REG_WORLD_N_A] +
                  ((anchor[REG_WORLD_N_B] - anchor[REG_WORLD_N_A]) >>> 8) * $urandom_range(300);
        end
      endcase
      tries++;
    end while (lookup_pix(row.e, row.n, res, addr) && !img_written[addr] && tries < 50);
    // still on an unloaded pixel: load it instead
    if (lookup_pix(row.e, row.n, res, addr) && !img_written[addr]) begin
      row.fn = FUNC_LOAD;
      row.idx = addr;
    end
  endtask

  task automatic rand_phase(input int count);
    stim_row_t row;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 40) begin
        row.fn = FUNC_LOAD;
        row.idx = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2047));
        row.rgb = 24'($urandom);
        row.e = $urandom;
        row.n = $urandom;
        row.known = 1'b0;
      end else rand_lookup(row);
      send_item(row);
    end
  endtask

  stim_row_t dir_tab[$];

  initial begin
    stim_row_t row;
    for (int i = 0; i < 8; i++) anchor[i] = i < 4 ? RST_ANCHOR_A : RST_ANCHOR_B;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset mapping is identity in Q23.8
    dir_tab.push_back('{FUNC_LOAD, 16'h0000, 24'h000000, 0, 0, 0, '0});
    dir_tab.push_back('{FUNC_LOAD, 16'hFFFF, 24'hFFFFFF, 0, 0, 0, '0});
    dir_tab.push_back('{FUNC_LOAD, 16'h0102, 24'hA55A3C, 0, 0, 0, '0});
    dir_tab.push_back('{FUNC_LOAD, 16'h00FF, 24'h123456, -1, -1, 0, '0});
    dir_tab.push_back('{FUNC_LOOKUP, 16'hFFFF, 24'hFFFFFF, 0, 0, 1, '{0, 0, 0, 0}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, 32'hFF00, 32'hFF00, 1, '{255, 255, 255, 0}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, 32'hFFFF, 32'hFFFF, 1, '{255, 255, 255, 1}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, 32'hFF01, 0, 1, '{255, 255, 255, 1}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, 0, 32'h1_0000, 1, '{255, 255, 255, 1}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, -1, 0, 1, '{255, 255, 255, 1}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, 0, -1, 1, '{255, 255, 255, 1}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, 32'h7FFFFFFF, 0, 1, '{255, 255, 255, 1}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, 32'h80000000, 32'h80000000, 1,
                       '{255, 255, 255, 1}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, 32'h2FF, 32'h1FF, 1, '{8'hA5, 8'h5A, 8'h3C, 0}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, 32'hFF00, 0, 1, '{8'h12, 8'h34, 8'h56, 0}});
    dir_tab.push_back('{FUNC_LOOKUP, 0, 0, 0, 0, 1, '{0, 0, 0, 0}});
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    drain();

    // zero span and huge quotient
    write_anchor(REG_WORLD_E_B, 32'd0);
    row = '{FUNC_LOOKUP, 0, 0, 0, 0, 1, '{255, 255, 255, 1}};
    send_item(row);
    drain();
    write_anchor(REG_WORLD_E_B, 32'd1);
    write_anchor(REG_PIX_X_B, 32'h7FFF_FFFF);
    row = '{FUNC_LOOKUP, 0, 0, 32'h7FFF_FFFF, 0, 1, '{255, 255, 255, 1}};
    send_item(row);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      // new anchors per phase: reset values on the first, extremes on the last
      case (ph)
        0: for (int r = 0; r < 8; r++) write_anchor(reg_idx_t'(r), r < 4 ? 0 : 256);
        5: begin
          write_anchor(REG_PIX_X_A, 32'h0000_FF00);
          write_anchor(REG_PIX_Y_A, 32'h0000_FF00);
          write_anchor(REG_PIX_X_B, 32'h0);
          write_anchor(REG_PIX_Y_B, 32'h0);
          write_anchor(REG_WORLD_E_A, 32'h8000_0000);
          write_anchor(REG_WORLD_N_A, 32'h7FFF_FFFF);
          write_anchor(REG_WORLD_E_B, 32'h7FFF_FFFF);
          write_anchor(REG_WORLD_N_B, 32'h8000_0000);
        end
        default: begin
          write_anchor(REG_PIX_X_A, $urandom_range(4096));
          write_anchor(REG_PIX_Y_A, $urandom_range(4096));
          write_anchor(REG_PIX_X_B, 32'($urandom_range(65535)) - 32'd4096);
          write_anchor(REG_PIX_Y_B, 32'($urandom_range(65535)) - 32'd4096);
          write_anchor(REG_WORLD_E_A, $urandom);
          write_anchor(REG_WORLD_N_A, $urandom);
          write_anchor(REG_WORLD_E_B, anchor[REG_WORLD_E_A] + 32'($urandom_range(1 << 20)) - 32'd4096);
          write_anchor(REG_WORLD_N_B, anchor[REG_WORLD_N_A] + 32'($urandom_range(1 << 20)) - 32'd4096);
        end
      endcase
      if (ph == 2) begin
        fork
          begin recv_hold = 1'b1; repeat (200) @(posedge clk); recv_hold = 1'b0; end
          rand_phase(190);
        join
      end else rand_phase(190);
      drain();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
